// ----- rtl/core/hsvrgb_pkg.sv -----
package hsvrgb_pkg;

  localparam int unsigned HueW    = 16;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SectorW = 3;
  localparam int unsigned H6W     = HueW + SectorW;
  localparam int unsigned DenW    = LevelW + FracW;
  localparam int unsigned ProdW   = LevelW + DenW;
  localparam int unsigned NumW    = 2 * LevelW;

  localparam logic [LevelW-1:0] FullScale = 8'd255;
  // 255 * 65536, the common denominator of q and t
  localparam logic [DenW-1:0]   Den       = 24'hFF0000;
  localparam logic [FracW:0]    FracOne   = 17'h10000;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [FracW-1:0]  frac_t;
  typedef logic [HueW-1:0]   hue_t;

  // sixths of the hue circle
  typedef enum logic [SectorW-1:0] {
    SectorRedYel = 3'd0,
    SectorYelGrn = 3'd1,
    SectorGrnCyn = 3'd2,
    SectorCynBlu = 3'd3,
    SectorBluMag = 3'd4,
    SectorMagRed = 3'd5
  } sector_e;

endpackage

// ----- rtl/core/hsvrgb_hsv_if.sv -----
interface hsvrgb_hsv_if import hsvrgb_pkg::*; ();

  logic   valid;
  logic   ready;
  hue_t   hue;
  level_t saturation;
  level_t brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);

endinterface

// ----- rtl/core/hsvrgb_rgb_if.sv -----
interface hsvrgb_rgb_if import hsvrgb_pkg::*; ();

  logic   valid;
  logic   ready;
  level_t red;
  level_t green;
  level_t blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);

endinterface

// ----- rtl/core/hsvrgb_div255.sv -----
// floor(num / 255) for num up to 255 * 255
module hsvrgb_div255 import hsvrgb_pkg::*; (
  input  logic [NumW-1:0] num_i,
  output level_t          quot_o
);

  level_t          hi;
  level_t          lo;
  logic [LevelW:0] rem;

  // num / 256 never overshoots; the remainder hi + lo stays below 2 * 255
  assign hi     = num_i[NumW-1:LevelW];
  assign lo     = num_i[LevelW-1:0];
  assign rem    = {1'b0, hi} + {1'b0, lo};
  assign quot_o = hi + level_t'(rem >= {1'b0, FullScale});

endmodule

// ----- rtl/core/hsv_to_rgb_color_convert.sv -----
// channel | modport | transfer when          | payload
// hsv_i   | sink    | valid && ready at edge | hue[15:0], saturation[7:0], brightness[7:0]
// rgb_o   | source  | valid && ready at edge | red[7:0], green[7:0], blue[7:0]
//
// four register stages: sector and p product, s*f products, v products,
// divide by 255 and sector select into the output register
// one colour per clock sustained while rgb_o.ready stays high
// rst_ni clears the stage valid bits only
// each stage moves on when empty or when the stage after it moves, so a stalled
// output holds its colour while earlier stages still fill their bubbles
module hsv_to_rgb_color_convert import hsvrgb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsvrgb_hsv_if.sink   hsv_i,
  hsvrgb_rgb_if.source rgb_o
);

  logic en1, en2, en3, en4;

  logic           s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  sector_e        s1_sector_q, s2_sector_q, s3_sector_q;
  frac_t          s1_frac_q;
  level_t         s1_sat_q;
  level_t         s1_val_q, s2_val_q, s3_val_q;
  logic [NumW-1:0] s1_pnum_q, s2_pnum_q, s3_pnum_q;
  logic [DenW-1:0] s2_qden_q, s2_tden_q;
  logic [NumW-1:0] s3_qnum_q, s3_tnum_q;
  level_t         red_q, green_q, blue_q;

  logic [H6W-1:0]   h6;
  level_t           sat_inv;
  logic [NumW-1:0]  pnum_d;
  logic [DenW-1:0]  sf_prod;
  logic [FracW:0]   frac_inv;
  logic [DenW:0]    st_prod;
  logic [ProdW-1:0] qprod, tprod;
  level_t           p, q, t;
  level_t           red_d, green_d, blue_d;

  assign en4 = ~out_valid_q | rgb_o.ready;
  assign en3 = ~s3_valid_q | en4;
  assign en2 = ~s2_valid_q | en3;
  assign en1 = ~s1_valid_q | en2;
  assign hsv_i.ready = en1;

  // stage 1: hue * 6 as shift-add, p numerator
  assign h6      = {1'b0, hsv_i.hue, 2'b00} + {2'b00, hsv_i.hue, 1'b0};
  assign sat_inv = FullScale - hsv_i.saturation;
  assign pnum_d  = {{LevelW{1'b0}}, hsv_i.brightness} * {{LevelW{1'b0}}, sat_inv};

  // stage 2: D - s*f and D - s*(1-f)
  assign sf_prod  = {{FracW{1'b0}}, s1_sat_q} * {{LevelW{1'b0}}, s1_frac_q};
  assign frac_inv = FracOne - {1'b0, s1_frac_q};
  assign st_prod  = {{(FracW+1){1'b0}}, s1_sat_q} * {{LevelW{1'b0}}, frac_inv};

  // stage 3: v times numerators, dropping the 65536 part of the denominator
  assign qprod = {{DenW{1'b0}}, s2_val_q} * {{LevelW{1'b0}}, s2_qden_q};
  assign tprod = {{DenW{1'b0}}, s2_val_q} * {{LevelW{1'b0}}, s2_tden_q};

  // stage 4: the remaining / 255, then the sector table
  hsvrgb_div255 u_div_p (.num_i(s3_pnum_q), .quot_o(p));
  hsvrgb_div255 u_div_q (.num_i(s3_qnum_q), .quot_o(q));
  hsvrgb_div255 u_div_t (.num_i(s3_tnum_q), .quot_o(t));

  // zero saturation needs no special arm: p, q and t all come out as v
  always_comb begin
    unique case (s3_sector_q)
      SectorRedYel: begin red_d = s3_val_q; green_d = t;        blue_d = p;        end
      SectorYelGrn: begin red_d = q;        green_d = s3_val_q; blue_d = p;        end
      SectorGrnCyn: begin red_d = p;        green_d = s3_val_q; blue_d = t;        end
      SectorCynBlu: begin red_d = p;        green_d = q;        blue_d = s3_val_q; end
      SectorBluMag: begin red_d = t;        green_d = p;        blue_d = s3_val_q; end
      default:      begin red_d = s3_val_q; green_d = p;        blue_d = q;        end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q  <= hsv_i.valid;
      if (en2) s2_valid_q  <= s1_valid_q;
      if (en3) s3_valid_q  <= s2_valid_q;
      if (en4) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_sector_q <= sector_e'(h6[H6W-1:FracW]);
      s1_frac_q   <= h6[FracW-1:0];
      s1_sat_q    <= hsv_i.saturation;
      s1_val_q    <= hsv_i.brightness;
      s1_pnum_q   <= pnum_d;
    end
    if (en2) begin
      s2_sector_q <= s1_sector_q;
      s2_val_q    <= s1_val_q;
      s2_pnum_q   <= s1_pnum_q;
      s2_qden_q   <= Den - sf_prod;
      s2_tden_q   <= Den - st_prod[DenW-1:0];
    end
    if (en3) begin
      s3_sector_q <= s2_sector_q;
      s3_val_q    <= s2_val_q;
      s3_pnum_q   <= s2_pnum_q;
      s3_qnum_q   <= qprod[ProdW-1:FracW];
      s3_tnum_q   <= tprod[ProdW-1:FracW];
    end
    if (en4) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = out_valid_q;
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

endmodule
